FILE: rtl/core/swq_pkg.sv
// swq_pkg: shared types and constants for the semaphore wait queue table
// no dependencies
package swq_pkg;

  localparam int MaxProcsDefault   = 32;
  localparam int DeviceSemsDefault = 32;
  localparam int KeyW              = 32;
  localparam int PidW              = 5;
  localparam int OpW               = 2;
  localparam int StW               = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_OUT    = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [StW-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // one classified command between front and back
  typedef struct packed {
    op_t             op;
    logic [KeyW-1:0] key;
    logic [PidW-1:0] pid;
    logic            pid_ok;   // pid below the process count
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_SCAN,
    BK_SCAN_WAIT,
    BK_DECIDE,
    BK_WALK,
    BK_WALK_WAIT,
    BK_APPLY,
    BK_PUSH
  } bk_state_t;

endpackage

FILE: rtl/core/swq_front.sv
// swq_front: accepts input words, classifies them and queues them for the back end
// depends on swq_pkg
module swq_front #(
  parameter int MAX_PROCS = swq_pkg::MaxProcsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [swq_pkg::OpW-1:0]     op,
  input  logic [swq_pkg::KeyW-1:0]    sem_key,
  input  logic [swq_pkg::PidW-1:0]    proc_id,
  output logic                        cmd_valid,
  output swq_pkg::cmd_t               cmd,
  input  logic                        cmd_take
);

  // two-entry command queue
  swq_pkg::cmd_t slot [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  swq_pkg::cmd_t incoming;
  logic          do_push, do_pop;

  always_comb begin
    incoming.op     = swq_pkg::op_t'(op);
    incoming.key    = sem_key;
    incoming.pid    = proc_id;
    incoming.pid_ok = ({27'd0, proc_id} < 32'(MAX_PROCS));
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: rtl/core/swq_back.sv
// swq_back: descriptor pool and process queues, runs one command at a time
// depends on swq_pkg
module swq_back #(
  parameter int MAX_PROCS   = swq_pkg::MaxProcsDefault,
  parameter int DEVICE_SEMS = swq_pkg::DeviceSemsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  swq_pkg::cmd_t              cmd,
  output logic                       cmd_take,
  output logic                       res_valid,
  output logic [swq_pkg::StW-1:0]    res_status,
  output logic [swq_pkg::PidW-1:0]   res_proc,
  input  logic                       res_ready
);

  localparam int NDesc = MAX_PROCS + DEVICE_SEMS;
  localparam int DW    = (NDesc > 1) ? $clog2(NDesc) : 1;
  localparam int PW    = swq_pkg::PidW;
  localparam int CW    = PW + 1;

  // descriptor store: key memory plus per-entry fields
  logic [swq_pkg::KeyW-1:0] dkey_mem [NDesc];
  logic [PW-1:0]            dhead_mem [NDesc];
  logic [PW-1:0]            dtail_mem [NDesc];
  logic [CW-1:0]            dcnt_mem [NDesc];
  logic [NDesc-1:0]         used;
  // process store
  logic [PW-1:0]            pnext_mem [MAX_PROCS];
  logic [swq_pkg::KeyW-1:0] pkey_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0]     waiting;

  swq_pkg::bk_state_t state, state_next;
  swq_pkg::cmd_t      cur;
  logic [swq_pkg::KeyW-1:0] key;
  logic [DW:0]        idx;
  logic [DW-1:0]      hit_d, free_d, d;
  logic               hit_f, free_f;
  logic [swq_pkg::KeyW-1:0] rd_key;
  logic [PW-1:0]      rd_head, rd_tail, walk_cur, walk_nx;
  logic [CW-1:0]      rd_cnt, k;
  logic [swq_pkg::StW-1:0] status;
  logic [PW-1:0]      outp;
  logic               rd_used;
  logic               out_ok, walk_head, walk_link, walk_more;
  logic [swq_pkg::StW-1:0] apply_st;
  logic [PW-1:0]      apply_out;

  function automatic logic [PW-1:0] pidx(input logic [PW-1:0] x);
    pidx = ({27'd0, x} < 32'(MAX_PROCS)) ? x : '0;
  endfunction

  assign cmd_take = (state == swq_pkg::BK_IDLE) && cmd_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      swq_pkg::BK_IDLE:      if (cmd_valid) state_next = swq_pkg::BK_LOOKUP;
      swq_pkg::BK_LOOKUP:    state_next = swq_pkg::BK_SCAN;
      swq_pkg::BK_SCAN:      state_next = swq_pkg::BK_SCAN_WAIT;
      swq_pkg::BK_SCAN_WAIT:
        state_next = (idx == (DW+1)'(NDesc - 1)) ? swq_pkg::BK_DECIDE : swq_pkg::BK_SCAN;
      swq_pkg::BK_DECIDE:    state_next = swq_pkg::BK_WALK;
      swq_pkg::BK_WALK:      state_next = swq_pkg::BK_WALK_WAIT;
      swq_pkg::BK_WALK_WAIT: state_next = swq_pkg::BK_APPLY;
      swq_pkg::BK_APPLY:
        state_next = walk_more ? swq_pkg::BK_APPLY : swq_pkg::BK_PUSH;
      swq_pkg::BK_PUSH:      if (!res_valid || res_ready) state_next = swq_pkg::BK_IDLE;
      default:               state_next = swq_pkg::BK_IDLE;
    endcase
  end

  // outcome of the apply stage and the next link of the out walk
  always_comb begin
    walk_nx   = pidx(pnext_mem[walk_cur]);
    out_ok    = (cur.op == swq_pkg::OP_OUT) && cur.pid_ok && waiting[cur.pid] && hit_f;
    walk_head = out_ok && (walk_cur == cur.pid);
    walk_link = out_ok && !walk_head && (k < rd_cnt) && (walk_nx == cur.pid);
    walk_more = out_ok && !walk_head && (k < rd_cnt) && (walk_nx != cur.pid);
    apply_st  = swq_pkg::ST_MISS;
    apply_out = '0;
    unique case (cur.op)
      swq_pkg::OP_INSERT:
        if (cur.pid_ok && !waiting[cur.pid]) begin
          apply_st = (hit_f || free_f) ? swq_pkg::ST_DONE : swq_pkg::ST_FULL;
        end
      swq_pkg::OP_REMOVE, swq_pkg::OP_PEEK:
        if (hit_f) begin
          apply_st  = swq_pkg::ST_DONE;
          apply_out = pidx(rd_head);
        end
      swq_pkg::OP_OUT:
        if (walk_head || walk_link) begin
          apply_st  = swq_pkg::ST_DONE;
          apply_out = cur.pid;
        end
    endcase
  end

  // memories read in clocked blocks
  always_ff @(posedge clk) begin
    rd_key  <= dkey_mem[idx[DW-1:0]];
    rd_used <= used[idx[DW-1:0]];
    rd_head <= dhead_mem[d];
    rd_tail <= dtail_mem[d];
    rd_cnt  <= dcnt_mem[d];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swq_pkg::BK_IDLE;
      used      <= '0;
      waiting   <= '0;
      res_valid <= 1'b0;
      cur       <= '0;
    end else begin
      state <= state_next;
      if (state == swq_pkg::BK_PUSH && (!res_valid || res_ready)) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        swq_pkg::BK_IDLE: if (cmd_valid) cur <= cmd;
        swq_pkg::BK_LOOKUP: begin
          key    <= (cur.op == swq_pkg::OP_OUT) ? pkey_mem[cur.pid] : cur.key;
          idx    <= '0;
          hit_f  <= 1'b0;
          free_f <= 1'b0;
        end
        swq_pkg::BK_SCAN: ;
        swq_pkg::BK_SCAN_WAIT: begin
          if (rd_used && rd_key == key && !hit_f) begin
            hit_f <= 1'b1;
            hit_d <= idx[DW-1:0];
          end
          if (!rd_used && !free_f) begin
            free_f <= 1'b1;
            free_d <= idx[DW-1:0];
          end
          if (idx != (DW+1)'(NDesc)) idx <= idx + 1'b1;
        end
        swq_pkg::BK_DECIDE: d <= hit_f ? hit_d : free_d;
        swq_pkg::BK_WALK: begin
          walk_cur <= '0;
          k        <= CW'(1);
        end
        swq_pkg::BK_WALK_WAIT: begin
          walk_cur <= pidx(rd_head);
        end
        swq_pkg::BK_APPLY: begin
          status <= apply_st;
          outp   <= apply_out;
          unique case (cur.op)
            swq_pkg::OP_INSERT:
              if (cur.pid_ok && !waiting[cur.pid] && (hit_f || free_f)) begin
                if (!hit_f) begin
                  used[d]      <= 1'b1;
                  dkey_mem[d]  <= key;
                  dhead_mem[d] <= cur.pid;
                  dcnt_mem[d]  <= CW'(1);
                end else begin
                  pnext_mem[pidx(rd_tail)] <= cur.pid;
                  dcnt_mem[d] <= rd_cnt + 1'b1;
                end
                dtail_mem[d]      <= cur.pid;
                waiting[cur.pid]  <= 1'b1;
                pkey_mem[cur.pid] <= key;
              end
            swq_pkg::OP_REMOVE: if (hit_f) begin
              dhead_mem[d] <= pidx(pnext_mem[pidx(rd_head)]);
              waiting[pidx(rd_head)] <= 1'b0;
              dcnt_mem[d] <= rd_cnt - 1'b1;
              if (rd_cnt == CW'(1)) used[d] <= 1'b0;
            end
            // out: walk the chain one link per cycle inside the apply stage
            swq_pkg::OP_OUT: begin
              if (walk_head) begin
                dhead_mem[d] <= pidx(pnext_mem[cur.pid]);
                waiting[cur.pid] <= 1'b0;
                dcnt_mem[d] <= rd_cnt - 1'b1;
                if (rd_cnt == CW'(1)) used[d] <= 1'b0;
              end else if (walk_link) begin
                pnext_mem[walk_cur] <= pnext_mem[cur.pid];
                if (pidx(rd_tail) == cur.pid) dtail_mem[d] <= walk_cur;
                waiting[cur.pid] <= 1'b0;
                dcnt_mem[d] <= rd_cnt - 1'b1;
                if (rd_cnt == CW'(1)) used[d] <= 1'b0;
              end else if (walk_more) begin
                walk_cur <= walk_nx;
                k        <= k + 1'b1;
              end
            end
            swq_pkg::OP_PEEK: ;
          endcase
        end
        swq_pkg::BK_PUSH: if (!res_valid || res_ready) begin
          res_status <= status;
          res_proc   <= outp;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/semaphore_wait_queue_table_core.sv
// semaphore_wait_queue_table_core: top level of the semaphore wait queue table
// depends on swq_pkg, swq_front, swq_back
//
//   channel   direction  handshake        fields
//   command   in         push / full      op, sem_key, proc_id
//   result    out        pop / empty      status, out_proc
//
// each word holds the back end through a serial key scan of every descriptor,
// read through the registered key memory, and for out through a walk of up to
// MAX_PROCS - 2 queue links
// rst is synchronous: pool empty, no process waiting, queues empty
// the front takes up to two words while the back end works; a held result
// stalls the back end only, not the front
module semaphore_wait_queue_table_core #(
  parameter int MAX_PROCS   = swq_pkg::MaxProcsDefault,
  parameter int DEVICE_SEMS = swq_pkg::DeviceSemsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [swq_pkg::OpW-1:0]   op,
  input  logic [swq_pkg::KeyW-1:0]  sem_key,
  input  logic [swq_pkg::PidW-1:0]  proc_id,
  output logic                      empty,
  input  logic                      pop,
  output logic [swq_pkg::StW-1:0]   status,
  output logic [swq_pkg::PidW-1:0]  out_proc
);

  logic          cmd_valid, cmd_take, res_valid;
  swq_pkg::cmd_t cmd;

  // front: accept and classify
  swq_front #(.MAX_PROCS(MAX_PROCS)) u_front (
    .clk, .rst, .push, .full, .op, .sem_key, .proc_id,
    .cmd_valid, .cmd, .cmd_take
  );

  // back: scan descriptors, update queues, hold the result word
  swq_back #(.MAX_PROCS(MAX_PROCS), .DEVICE_SEMS(DEVICE_SEMS)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res_status(status), .res_proc(out_proc), .res_ready(pop)
  );

  assign empty = !res_valid;

endmodule
